### design/line_column_field_selector_core_macros.svh
// assertion macros
`ifndef LINE_COLUMN_FIELD_SELECTOR_CORE_MACROS_SVH
`define LINE_COLUMN_FIELD_SELECTOR_CORE_MACROS_SVH
`ifndef ASSERT_OFF
`define LCFS_ASSERT_IMPLIES(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("assertion failed");
`define LCFS_ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("assertion failed");
`else
`define LCFS_ASSERT_IMPLIES(label, clk, rst, a, b)
`define LCFS_ASSERT_NEXT(label, clk, rst, a, b)
`endif
`endif

### design/lcfs_pkg.sv
package lcfs_pkg;

  localparam logic [7:0] NEWLINE = 8'd10;
  localparam logic [7:0] TAB = 8'd9;

  localparam int FL_W = 6;
  localparam int CMD_DEPTH = 4;
  localparam int CMD_PTR_W = 2;

  localparam logic [1:0] MODE_CHAR = 2'd1;
  localparam logic [1:0] MODE_FIELD = 2'd2;

  localparam logic [2:0] REG_MODE = 3'd0;
  localparam logic [2:0] REG_SEP = 3'd1;
  localparam logic [2:0] REG_DROP = 3'd2;
  localparam logic [2:0] REG_COUNT = 3'd3;

  localparam int P_FF = 3;
  localparam int P_MAIN = 4;
  localparam int P_NL = 5;

  typedef struct packed {
    logic [2:0][7:0] hold;
    logic [5:0] pend;
    logic [FL_W-1:0] ff_len;
    logic ff_tr;
    logic [7:0] main_byte;
    logic main_tr;
    logic nl_tr;
  } cmd_t;

  typedef struct packed {
    logic we;
    logic [FL_W-1:0] addr;
    logic [7:0] data;
  } ffwr_t;

  function automatic logic has(input logic [3:0][63:0] r, input logic [2:0] cnt,
                               input logic [31:0] n);
    logic res;
    logic done;
    res = 1'b0;
    done = 1'b0;
    for (int i = 0; i < 4; i++) begin
      if (!done && 3'(i) < cnt) begin
        if (n < r[i][31:0]) begin
          done = 1'b1;
        end else if (r[i][63:32] == 32'd0 || n <= r[i][63:32]) begin
          res = 1'b1;
          done = 1'b1;
        end
      end
    end
    return res;
  endfunction

  function automatic logic [2:0] lead_len(input logic [7:0] b);
    logic [2:0] len;
    len = 3'd0;
    if (b < 8'h80) len = 3'd1;
    else if (b inside {[8'hC2:8'hDF]}) len = 3'd2;
    else if (b inside {[8'hE0:8'hEF]}) len = 3'd3;
    else if (b inside {[8'hF0:8'hF4]}) len = 3'd4;
    return len;
  endfunction

  function automatic logic cont_ok(input logic [7:0] lead, input logic [1:0] pos,
                                   input logic [7:0] b);
    logic [7:0] lo;
    logic [7:0] hi;
    lo = 8'h80;
    hi = 8'hBF;
    if (pos == 2'd1) begin
      if (lead == 8'hE0) lo = 8'hA0;
      if (lead == 8'hED) hi = 8'h9F;
      if (lead == 8'hF0) lo = 8'h90;
      if (lead == 8'hF4) hi = 8'h8F;
    end
    return b >= lo && b <= hi;
  endfunction

endpackage

### design/line_column_field_selector_core.sv
// path: a taken item's command goes through the command FIFO and the back end's command
// register to the registered result ports; throughput: one item per cycle while the back
// end keeps up; bytes go out singly; input waits until a buffered first field is sent
// reset: synchronous rst clears line state, command queue and output, sets registers
// to their reset values; the first field buffer is not cleared
`include "line_column_field_selector_core_macros.svh"

module line_column_field_selector_core
  import lcfs_pkg::*;
#(
  parameter int RANGE_SLOTS = 4,
  parameter int FIRST_FIELD_DEPTH = 32,
  parameter int COUNT_WIDTH = 32
) (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic [2:0] cfg_index,
  input  logic [63:0] cfg_data,
  input  logic push,
  output logic full,
  input  logic kind,
  input  logic [7:0] data_byte,
  output logic empty,
  input  logic pop,
  output logic [7:0] out_byte,
  output logic last,
  output logic truncated
);

  cmd_t cmd_in, cmd_out;
  ffwr_t ffwr;
  logic cmd_push, fifo_pop, fifo_empty, fifo_full, ff_done;

  lcfs_front #(
    .RANGE_SLOTS(RANGE_SLOTS),
    .FIRST_FIELD_DEPTH(FIRST_FIELD_DEPTH),
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_front (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .push(push),
    .kind(kind),
    .data_byte(data_byte),
    .fifo_full(fifo_full),
    .ff_done(ff_done),
    .full(full),
    .cmd_push(cmd_push),
    .cmd(cmd_in),
    .ffwr(ffwr)
  );

  lcfs_cmd_fifo u_fifo (
    .clk(clk),
    .rst(rst),
    .wr_en(cmd_push),
    .wr_data(cmd_in),
    .rd_en(fifo_pop),
    .rd_data(cmd_out),
    .empty(fifo_empty),
    .full(fifo_full)
  );

  lcfs_back #(
    .FIRST_FIELD_DEPTH(FIRST_FIELD_DEPTH)
  ) u_back (
    .clk(clk),
    .rst(rst),
    .fifo_empty(fifo_empty),
    .fifo_data(cmd_out),
    .fifo_pop(fifo_pop),
    .ffwr(ffwr),
    .pop(pop),
    .empty(empty),
    .out_byte(out_byte),
    .last(last),
    .truncated(truncated),
    .ff_done(ff_done)
  );

  `LCFS_ASSERT_IMPLIES(a_wr_on_transfer, clk, rst, ffwr.we, push && !full)
  `LCFS_ASSERT_IMPLIES(a_cmd_room, clk, rst, cmd_push, !fifo_full)
  `LCFS_ASSERT_IMPLIES(a_cmd_nonempty, clk, rst, cmd_push, cmd_in.pend != 6'd0)
  `LCFS_ASSERT_NEXT(a_ff_blocks_input, clk, rst, cmd_push && cmd_in.pend[P_FF], full)

endmodule

### design/lcfs_cmd_fifo.sv
module lcfs_cmd_fifo
  import lcfs_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic wr_en,
  input  cmd_t wr_data,
  input  logic rd_en,
  output cmd_t rd_data,
  output logic empty,
  output logic full
);

  cmd_t slots [CMD_DEPTH];
  logic [CMD_PTR_W-1:0] wp;
  logic [CMD_PTR_W-1:0] rp;
  logic [CMD_PTR_W:0] cnt;

  assign empty = (cnt == '0);
  assign full = (cnt == (CMD_PTR_W+1)'(CMD_DEPTH));
  assign rd_data = slots[rp];

  always_ff @(posedge clk) begin
    if (wr_en) slots[wp] <= wr_data;
    if (rst) begin
      wp <= '0;
      rp <= '0;
      cnt <= '0;
    end else begin
      if (wr_en) wp <= wp + 1'b1;
      if (rd_en) rp <= rp + 1'b1;
      if (wr_en && !rd_en) cnt <= cnt + 1'b1;
      else if (rd_en && !wr_en) cnt <= cnt - 1'b1;
    end
  end

endmodule

### design/lcfs_front.sv
module lcfs_front
  import lcfs_pkg::*;
#(
  parameter int RANGE_SLOTS = 4,
  parameter int FIRST_FIELD_DEPTH = 32,
  parameter int COUNT_WIDTH = 32
) (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic [2:0] cfg_index,
  input  logic [63:0] cfg_data,
  input  logic push,
  input  logic kind,
  input  logic [7:0] data_byte,
  input  logic fifo_full,
  input  logic ff_done,
  output logic full,
  output logic cmd_push,
  output cmd_t cmd,
  output ffwr_t ffwr
);

  logic [1:0] mode;
  logic [7:0] sep;
  logic drop;
  logic [2:0] rcount;
  logic [3:0][63:0] ranges;

  logic [COUNT_WIDTH-1:0] col, col_next;
  logic [COUNT_WIDTH-1:0] fcnt, fcnt_next;
  logic sep_seen, sep_seen_next;
  logic kept, kept_next;
  logic started, started_next;
  logic [FL_W-1:0] ff_len, ff_len_next;
  logic ff_ov, ff_ov_next;
  logic [2:0][7:0] hold, hold_next;
  logic [1:0] held_cnt, held_next;
  logic [2:0] expected, exp_next;
  logic ff_wait, ff_wait_next;

  logic [2:0] rc;
  logic [4:0][COUNT_WIDTH-1:0] p;
  logic [4:0] has_p;
  logic has_one, has_fc, has_fc_new, kept_eff, accept;
  logic [COUNT_WIDTH-1:0] fc_new;
  logic [2:0] len;

  function automatic logic [COUNT_WIDTH-1:0] sat(input logic [COUNT_WIDTH-1:0] v);
    return (v == {COUNT_WIDTH{1'b1}}) ? v : v + 1'b1;
  endfunction

  assign rc = (rcount > 3'(RANGE_SLOTS)) ? 3'(RANGE_SLOTS) : rcount;
  assign full = fifo_full || ff_wait;
  assign accept = push && !full;
  assign len = lead_len(data_byte);

  always_comb begin
    for (int k = 0; k < 5; k++) begin
      p[k] = (col > {COUNT_WIDTH{1'b1}} - COUNT_WIDTH'(k)) ? {COUNT_WIDTH{1'b1}} :
             col + COUNT_WIDTH'(k);
    end
    for (int k = 0; k < 5; k++) has_p[k] = has(ranges, rc, 32'(p[k]));
    has_one = has(ranges, rc, 32'd1);
    fc_new = sep_seen ? sat(fcnt) : COUNT_WIDTH'(2);
    has_fc = has(ranges, rc, 32'(fcnt));
    has_fc_new = has(ranges, rc, 32'(fc_new));
  end

  always_comb begin
    col_next = col;
    fcnt_next = fcnt;
    sep_seen_next = sep_seen;
    kept_next = kept;
    started_next = started;
    ff_len_next = ff_len;
    ff_ov_next = ff_ov;
    hold_next = hold;
    held_next = held_cnt;
    exp_next = expected;
    kept_eff = kept;
    cmd = '0;
    cmd.hold = hold;
    cmd.ff_len = ff_len;
    cmd.main_byte = data_byte;
    ffwr.we = 1'b0;
    ffwr.addr = ff_len;
    ffwr.data = data_byte;
    if (accept) begin
      if (kind || data_byte == NEWLINE) begin
        if (!kind || started) begin
          if (mode == MODE_FIELD) begin
            if (sep_seen) begin
              cmd.pend[P_NL] = 1'b1;
            end else if (!drop) begin
              cmd.pend[P_FF] = (ff_len != '0);
              cmd.ff_tr = ff_ov;
              cmd.pend[P_NL] = 1'b1;
              cmd.nl_tr = ff_ov;
            end
          end else begin
            if (mode == MODE_CHAR) begin
              for (int i = 0; i < 3; i++) cmd.pend[i] = (2'(i) < held_cnt) && has_p[i+1];
            end
            cmd.pend[P_NL] = 1'b1;
          end
          col_next = '0;
          fcnt_next = '0;
          sep_seen_next = 1'b0;
          kept_next = 1'b0;
          started_next = 1'b0;
          ff_len_next = '0;
          ff_ov_next = 1'b0;
          held_next = '0;
          exp_next = '0;
        end
      end else begin
        started_next = 1'b1;
        case (mode)
          MODE_FIELD: begin
            if (data_byte == sep) begin
              if (!sep_seen) begin
                sep_seen_next = 1'b1;
                if (has_one) begin
                  cmd.pend[P_FF] = (ff_len != '0);
                  cmd.ff_tr = ff_ov;
                end
              end
              fcnt_next = fc_new;
              kept_eff = kept || (!sep_seen && has_one);
              kept_next = kept_eff;
              if (has_fc_new) begin
                cmd.pend[P_MAIN] = kept_eff;
                cmd.main_byte = sep;
                cmd.main_tr = !sep_seen && ff_ov;
                kept_next = 1'b1;
              end
            end else if (sep_seen) begin
              cmd.pend[P_MAIN] = has_fc;
            end else if (ff_len < FL_W'(FIRST_FIELD_DEPTH)) begin
              ffwr.we = 1'b1;
              ff_len_next = ff_len + 1'b1;
            end else begin
              ff_ov_next = 1'b1;
            end
          end
          MODE_CHAR: begin
            if (held_cnt != '0 && cont_ok(hold[0], held_cnt, data_byte)) begin
              if ({1'b0, held_cnt} + 3'd1 >= expected) begin
                col_next = p[1];
                if (has_p[1]) begin
                  for (int i = 0; i < 3; i++) cmd.pend[i] = (2'(i) < held_cnt);
                  cmd.pend[P_MAIN] = 1'b1;
                end
                held_next = '0;
                exp_next = '0;
              end else if (held_cnt < 2'd3) begin
                hold_next[held_cnt] = data_byte;
                held_next = held_cnt + 1'b1;
              end
            end else begin
              for (int i = 0; i < 3; i++) cmd.pend[i] = (2'(i) < held_cnt) && has_p[i+1];
              if (len <= 3'd1) begin
                col_next = p[3'(held_cnt) + 3'd1];
                cmd.pend[P_MAIN] = has_p[3'(held_cnt) + 3'd1];
                held_next = '0;
                exp_next = '0;
              end else begin
                col_next = p[3'(held_cnt)];
                hold_next[0] = data_byte;
                held_next = 2'd1;
                exp_next = len;
              end
            end
          end
          default: begin
            col_next = p[1];
            cmd.pend[P_MAIN] = has_p[1];
          end
        endcase
      end
    end
    cmd_push = accept && (cmd.pend != '0);
    ff_wait_next = ff_wait;
    if (ff_done) ff_wait_next = 1'b0;
    if (cmd_push && cmd.pend[P_FF]) ff_wait_next = 1'b1;
  end

  always_ff @(posedge clk) begin
    hold <= hold_next;
    if (rst) begin
      mode <= '0;
      sep <= TAB;
      drop <= 1'b0;
      rcount <= '0;
      ranges <= '0;
      col <= '0;
      fcnt <= '0;
      sep_seen <= 1'b0;
      kept <= 1'b0;
      started <= 1'b0;
      ff_len <= '0;
      ff_ov <= 1'b0;
      held_cnt <= '0;
      expected <= '0;
      ff_wait <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_MODE: mode <= cfg_data[1:0];
          REG_SEP: sep <= cfg_data[7:0];
          REG_DROP: drop <= cfg_data[0];
          REG_COUNT: rcount <= cfg_data[2:0];
          default: ranges[cfg_index[1:0]] <= cfg_data;
        endcase
      end
      col <= col_next;
      fcnt <= fcnt_next;
      sep_seen <= sep_seen_next;
      kept <= kept_next;
      started <= started_next;
      ff_len <= ff_len_next;
      ff_ov <= ff_ov_next;
      held_cnt <= held_next;
      expected <= exp_next;
      ff_wait <= ff_wait_next;
    end
  end

endmodule

### design/lcfs_back.sv
module lcfs_back
  import lcfs_pkg::*;
#(
  parameter int FIRST_FIELD_DEPTH = 32
) (
  input  logic clk,
  input  logic rst,
  input  logic fifo_empty,
  input  cmd_t fifo_data,
  output logic fifo_pop,
  input  ffwr_t ffwr,
  input  logic pop,
  output logic empty,
  output logic [7:0] out_byte,
  output logic last,
  output logic truncated,
  output logic ff_done
);

  localparam int AW = (FIRST_FIELD_DEPTH > 1) ? $clog2(FIRST_FIELD_DEPTH) : 1;

  logic [7:0] mem [FIRST_FIELD_DEPTH];
  logic [7:0] rd_data;
  cmd_t cmd;
  logic cmd_valid, cmd_valid_next;
  logic [5:0] pend, pend_next, pend_after, cur;
  logic [FL_W-1:0] ff_i, ff_i_next;
  logic out_valid;
  logic emit, fin, load, ff_more;
  logic [7:0] sel_byte;
  logic sel_tr;

  assign empty = !out_valid;

  always_comb begin
    emit = cmd_valid && (!out_valid || pop);
    cur = pend & (~pend + 6'd1);
    ff_more = (ff_i + 1'b1) < cmd.ff_len;
    pend_after = pend & ~((cur[P_FF] && ff_more) ? 6'd0 : cur);
    fin = emit && (pend_after == '0);
    load = !fifo_empty && (!cmd_valid || fin);
    fifo_pop = load;
    ff_done = emit && cur[P_FF] && !ff_more;
    sel_byte = NEWLINE;
    sel_tr = cmd.nl_tr;
    if (cur[0]) begin
      sel_byte = cmd.hold[0];
      sel_tr = 1'b0;
    end else if (cur[1]) begin
      sel_byte = cmd.hold[1];
      sel_tr = 1'b0;
    end else if (cur[2]) begin
      sel_byte = cmd.hold[2];
      sel_tr = 1'b0;
    end else if (cur[P_FF]) begin
      sel_byte = rd_data;
      sel_tr = cmd.ff_tr;
    end else if (cur[P_MAIN]) begin
      sel_byte = cmd.main_byte;
      sel_tr = cmd.main_tr;
    end
    pend_next = load ? fifo_data.pend : (emit ? pend_after : pend);
    cmd_valid_next = load ? 1'b1 : (fin ? 1'b0 : cmd_valid);
    ff_i_next = load ? '0 : ((emit && cur[P_FF]) ? ff_i + 1'b1 : ff_i);
  end

  always_ff @(posedge clk) begin
    if (ffwr.we) mem[ffwr.addr[AW-1:0]] <= ffwr.data;
    rd_data <= mem[ff_i_next[AW-1:0]];
    if (load) cmd <= fifo_data;
    ff_i <= ff_i_next;
    if (emit) begin
      out_byte <= sel_byte;
      last <= fin;
      truncated <= sel_tr;
    end
    if (rst) begin
      cmd_valid <= 1'b0;
      pend <= '0;
      out_valid <= 1'b0;
    end else begin
      cmd_valid <= cmd_valid_next;
      pend <= pend_next;
      if (emit) out_valid <= 1'b1;
      else if (pop) out_valid <= 1'b0;
    end
  end

endmodule
